// File: hdl/vspc_pkg.sv
// vspc_pkg: shared types and codes for the virtual subnet policy check
// used by vspc_tbl_ram, vspc_match and virtual_subnet_policy_check_top
`default_nettype none

package vspc_pkg;

	typedef struct packed {
		logic        fam;
		logic [7:0]  pfx;
		logic [63:0] hi;
		logic [63:0] lo;
	} entry_t;

	localparam logic       REQ_LOAD  = 1'b0;
	localparam logic       REQ_CHECK = 1'b1;

	localparam logic [1:0] TBL_ALLOW  = 2'd0;
	localparam logic [1:0] TBL_DENY   = 2'd1;
	localparam logic [1:0] TBL_CONN   = 2'd2;
	localparam logic [1:0] NUM_TABLES = 2'd3;

	localparam logic [1:0] VC_ACCEPT   = 2'd0;
	localparam logic [1:0] VC_HOST     = 2'd1;
	localparam logic [1:0] VC_PRIVATE  = 2'd2;
	localparam logic [1:0] VC_SPECIFIC = 2'd3;

	localparam logic [2:0] REG_VIRT_ENABLED  = 3'd0;
	localparam logic [2:0] REG_HOST_ONLY     = 3'd1;
	localparam logic [2:0] REG_ACCEPT_PUBLIC = 3'd2;
	localparam logic [2:0] REG_USE_PRIVATE   = 3'd3;
	localparam logic [2:0] REG_ACCEPT_ALL    = 3'd4;
	localparam logic [2:0] REG_CNT_ALLOW     = 3'd5;
	localparam logic [2:0] REG_CNT_DENY      = 3'd6;
	localparam logic [2:0] REG_CNT_CONN      = 3'd7;

	localparam logic [7:0] HOST_PFX_V4 = 8'd32;
	localparam logic [7:0] HOST_PFX_V6 = 8'd128;

endpackage

`default_nettype wire

// File: hdl/virtual_subnet_policy_check_top.sv
// virtual_subnet_policy_check_top: rule sequencer, config registers and stream ports
// depends on vspc_pkg, vspc_tbl_ram and vspc_match
//
//  channel  | dir | handshake          | contents
//  s_*      | in  | s_tvalid/s_tready  | load or check beat
//  m_*      | out | m_tvalid/m_tready  | verdict beat, check beats only
//  cfg_*    | in  | cfg_we             | register index and value
//
// a load beat writes the entry memory at acceptance
// a check beat may have the shared match unit walk the allow, deny and connection tables
// as the rules call for, one entry per cycle off the memory read port
// arst_n clears control and config; the entry memory is not cleared
// a waiting verdict holds in the output register while the next beat is accepted
`default_nettype none

module virtual_subnet_policy_check_top #(
	parameter int LIST_DEPTH = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// entry_index, net_family, net_hi, net_lo, net_prefix,
	// peer_addr_family, peer_addr_hi, peer_addr_lo, zero pad
	input  wire logic [271:0] s_tdata,
	// req_type, list_sel
	input  wire logic [2:0]   s_tuser,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// allowed, verdict_code, zero pad
	output logic [7:0]        m_tdata,
	input  wire logic         cfg_we,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [4:0]   cfg_data
);

	localparam int DEPTH = 3 * LIST_DEPTH;
	localparam int AW    = (DEPTH > 2) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(LIST_DEPTH + 1);
	localparam int NW    = (CW > 5) ? CW : 5;
	localparam int XW    = 11;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_RULES = 2'd1;
	localparam logic [1:0] ST_WALK  = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0]  st_q;
	logic [1:0]  tbl_q;
	logic [1:0]  why_q;
	logic [CW-1:0] idx_q;
	logic        hit_q;
	logic        rd_v_s1;
	logic        m_tvalid_q;
	logic [1:0]  verdict_q;

	logic        virt_q, host_only_q, acc_pub_q, use_priv_q, acc_all_q;
	logic [4:0]  cnt_allow_q, cnt_deny_q, cnt_conn_q;

	logic        fam_q, pfam_q;
	logic [63:0] hi_q, lo_q, phi_q, plo_q;
	logic [7:0]  pfx_q;

	logic        in_req;
	logic [1:0]  in_sel;
	logic [3:0]  in_idx;
	logic        in_fam;
	logic [63:0] in_hi, in_lo;
	logic [7:0]  in_pfx;
	logic        in_pfam;
	logic [63:0] in_phi, in_plo;
	logic        accept;

	logic        wr_en;
	logic [XW-1:0] wr_full;
	logic [XW-1:0] rd_full;
	vspc_pkg::entry_t wr_ent;
	vspc_pkg::entry_t rd_ent;

	logic [NW-1:0] lim_raw;
	logic [NW-1:0] n_lim;
	logic        issue;
	logic        hit_w;
	logic        is_host;
	logic        peer_eq;
	logic        conn_go;

	assign in_req  = s_tuser[0];
	assign in_sel  = s_tuser[2:1];
	assign in_idx  = s_tdata[3:0];
	assign in_fam  = s_tdata[4];
	assign in_hi   = in_fam ? s_tdata[68:5] : 64'd0;
	assign in_lo   = in_fam ? s_tdata[132:69] : {32'd0, s_tdata[100:69]};
	assign in_pfx  = s_tdata[140:133];
	assign in_pfam = s_tdata[141];
	assign in_phi  = in_pfam ? s_tdata[205:142] : 64'd0;
	assign in_plo  = in_pfam ? s_tdata[269:206] : {32'd0, s_tdata[237:206]};

	assign s_tready = (st_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {5'd0, verdict_q, (verdict_q == vspc_pkg::VC_ACCEPT)};

	// load path
	assign wr_en = accept && (in_req == vspc_pkg::REQ_LOAD) && (in_sel < vspc_pkg::NUM_TABLES)
		&& ({{(XW-4){1'b0}}, in_idx} < XW'(LIST_DEPTH));
	assign wr_full = XW'(in_sel) * XW'(LIST_DEPTH) + XW'(in_idx);
	assign wr_ent  = '{fam: in_fam, pfx: in_pfx, hi: in_hi, lo: in_lo};

	// walk path
	always_comb begin
		case (tbl_q)
			vspc_pkg::TBL_ALLOW: lim_raw = NW'(cnt_allow_q);
			vspc_pkg::TBL_DENY:  lim_raw = NW'(cnt_deny_q);
			default:             lim_raw = NW'(cnt_conn_q);
		endcase
		n_lim = (lim_raw > NW'(LIST_DEPTH)) ? NW'(LIST_DEPTH) : lim_raw;
	end

	assign issue   = (st_q == ST_WALK) && (NW'(idx_q) < n_lim);
	assign rd_full = XW'(tbl_q) * XW'(LIST_DEPTH) + XW'(idx_q);
	assign is_host = (pfx_q == (fam_q ? vspc_pkg::HOST_PFX_V6 : vspc_pkg::HOST_PFX_V4));
	assign peer_eq = (pfam_q == fam_q) && (phi_q == hi_q) && (plo_q == lo_q);
	assign conn_go = (cnt_conn_q != 5'd0);

	vspc_tbl_ram #(
		.DEPTH(DEPTH),
		.AW(AW)
	) u_ram (
		.clk(clk),
		.we(wr_en),
		.waddr(wr_full[AW-1:0]),
		.wdata(wr_ent),
		.re(issue),
		.raddr(rd_full[AW-1:0]),
		.rdata(rd_ent)
	);

	vspc_match u_match (
		.net_fam(fam_q),
		.net_hi(hi_q),
		.net_lo(lo_q),
		.net_pfx(pfx_q),
		.ent(rd_ent),
		.hit(hit_w)
	);

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			virt_q      <= 1'b0;
			host_only_q <= 1'b0;
			acc_pub_q   <= 1'b0;
			use_priv_q  <= 1'b0;
			acc_all_q   <= 1'b0;
			cnt_allow_q <= 5'd0;
			cnt_deny_q  <= 5'd0;
			cnt_conn_q  <= 5'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				vspc_pkg::REG_VIRT_ENABLED:  virt_q      <= cfg_data[0];
				vspc_pkg::REG_HOST_ONLY:     host_only_q <= cfg_data[0];
				vspc_pkg::REG_ACCEPT_PUBLIC: acc_pub_q   <= cfg_data[0];
				vspc_pkg::REG_USE_PRIVATE:   use_priv_q  <= cfg_data[0];
				vspc_pkg::REG_ACCEPT_ALL:    acc_all_q   <= cfg_data[0];
				vspc_pkg::REG_CNT_ALLOW:     cnt_allow_q <= cfg_data;
				vspc_pkg::REG_CNT_DENY:      cnt_deny_q  <= cfg_data;
				vspc_pkg::REG_CNT_CONN:      cnt_conn_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// request payload
	always_ff @(posedge clk) begin
		if (accept) begin
			fam_q  <= in_fam;
			hi_q   <= in_hi;
			lo_q   <= in_lo;
			pfx_q  <= in_pfx;
			pfam_q <= in_pfam;
			phi_q  <= in_phi;
			plo_q  <= in_plo;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_IDLE;
			tbl_q      <= vspc_pkg::TBL_ALLOW;
			why_q      <= vspc_pkg::VC_ACCEPT;
			idx_q      <= '0;
			hit_q      <= 1'b0;
			rd_v_s1    <= 1'b0;
			m_tvalid_q <= 1'b0;
			verdict_q  <= vspc_pkg::VC_ACCEPT;
		end else begin
			if ((st_q == ST_DONE) && (!m_tvalid_q || m_tready)) begin
				m_tvalid_q <= 1'b1;
				verdict_q  <= why_q;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			rd_v_s1 <= issue;
			case (st_q)
				ST_IDLE: begin
					if (accept && (in_req == vspc_pkg::REQ_CHECK)) begin
						st_q <= ST_RULES;
					end
				end
				ST_RULES: begin
					idx_q <= '0;
					hit_q <= 1'b0;
					if (!virt_q) begin
						why_q <= vspc_pkg::VC_ACCEPT;
						st_q  <= ST_DONE;
					end else if (host_only_q && !is_host) begin
						why_q <= vspc_pkg::VC_HOST;
						st_q  <= ST_DONE;
					end else if (acc_pub_q && is_host && peer_eq) begin
						why_q <= vspc_pkg::VC_ACCEPT;
						st_q  <= ST_DONE;
					end else if (use_priv_q) begin
						tbl_q <= vspc_pkg::TBL_ALLOW;
						st_q  <= ST_WALK;
					end else if (conn_go) begin
						tbl_q <= vspc_pkg::TBL_CONN;
						st_q  <= ST_WALK;
					end else begin
						why_q <= vspc_pkg::VC_ACCEPT;
						st_q  <= ST_DONE;
					end
				end
				ST_WALK: begin
					if (issue) begin
						idx_q <= idx_q + CW'(1);
					end
					if (rd_v_s1 && hit_w) begin
						hit_q <= 1'b1;
					end
					if (!issue && !rd_v_s1) begin
						// table finished
						idx_q <= '0;
						hit_q <= 1'b0;
						case (tbl_q)
							vspc_pkg::TBL_ALLOW: begin
								if (hit_q) begin
									tbl_q <= vspc_pkg::TBL_DENY;
								end else if (conn_go) begin
									why_q <= vspc_pkg::VC_PRIVATE;
									tbl_q <= vspc_pkg::TBL_CONN;
								end else begin
									why_q <= acc_all_q ? vspc_pkg::VC_ACCEPT
										: vspc_pkg::VC_PRIVATE;
									st_q  <= ST_DONE;
								end
							end
							vspc_pkg::TBL_DENY: begin
								if (!hit_q) begin
									why_q <= vspc_pkg::VC_ACCEPT;
									st_q  <= ST_DONE;
								end else if (conn_go) begin
									why_q <= vspc_pkg::VC_PRIVATE;
									tbl_q <= vspc_pkg::TBL_CONN;
								end else begin
									why_q <= acc_all_q ? vspc_pkg::VC_ACCEPT
										: vspc_pkg::VC_PRIVATE;
									st_q  <= ST_DONE;
								end
							end
							default: begin
								if (hit_q || acc_all_q) begin
									why_q <= vspc_pkg::VC_ACCEPT;
								end else begin
									why_q <= vspc_pkg::VC_SPECIFIC;
								end
								st_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_allowed_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[0] == (m_tdata[2:1] == vspc_pkg::VC_ACCEPT)))
		else $error("allowed flag disagrees with verdict code");

	a_read_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		rd_v_s1 |-> (st_q == ST_WALK))
		else $error("entry read returned outside the table walk");

	a_load_stays_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (in_req == vspc_pkg::REQ_LOAD)) |=> (st_q == ST_IDLE))
		else $error("load beat started a check");

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_WALK) |-> (NW'(idx_q) <= n_lim))
		else $error("walk index ran past the table count");
`endif

endmodule

`default_nettype wire

// File: hdl/vspc_tbl_ram.sv
// vspc_tbl_ram: subnet entry memory for all three tables, one write and one read port
// read data is registered; depends on vspc_pkg
`default_nettype none

module vspc_tbl_ram #(
	parameter int DEPTH = 48,
	parameter int AW    = 6
) (
	input  wire logic            clk,
	input  wire logic            we,
	input  wire logic [AW-1:0]   waddr,
	input  wire vspc_pkg::entry_t wdata,
	input  wire logic            re,
	input  wire logic [AW-1:0]   raddr,
	output vspc_pkg::entry_t     rdata
);

	vspc_pkg::entry_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// File: hdl/vspc_match.sv
// vspc_match: compares one proposed subnet against one table entry under the entry mask
// depends on vspc_pkg
`default_nettype none

module vspc_match (
	input  wire logic          net_fam,
	input  wire logic [63:0]   net_hi,
	input  wire logic [63:0]   net_lo,
	input  wire logic [7:0]    net_pfx,
	input  wire vspc_pkg::entry_t ent,
	output logic               hit
);

	logic [7:0]   len4;
	logic [7:0]   len6;
	logic [31:0]  mask4;
	logic [127:0] mask6;
	logic [127:0] mask;
	logic [127:0] diff;

	always_comb begin
		len4  = (ent.pfx > vspc_pkg::HOST_PFX_V4) ? vspc_pkg::HOST_PFX_V4 : ent.pfx;
		len6  = (ent.pfx > vspc_pkg::HOST_PFX_V6) ? vspc_pkg::HOST_PFX_V6 : ent.pfx;
		mask4 = (len4 == 8'd0) ? 32'd0 : ({32{1'b1}} << (vspc_pkg::HOST_PFX_V4 - len4));
		mask6 = (len6 == 8'd0) ? 128'd0 : ({128{1'b1}} << (vspc_pkg::HOST_PFX_V6 - len6));
		mask  = ent.fam ? mask6 : {96'd0, mask4};
		diff  = ({net_hi, net_lo} ^ {ent.hi, ent.lo}) & mask;
		hit   = (ent.fam == net_fam) && (net_pfx >= ent.pfx) && (diff == 128'd0);
	end

endmodule

`default_nettype wire

// File: tb/sv/subnet_policy_checker.sv
`timescale 1ns / 1ps
// subnet_policy_checker: watches the load/check, verdict and config channels of
// virtual_subnet_policy_check_top, predicts each verdict and compares it; uses vspc_pkg

module subnet_policy_checker #(
	parameter int LIST_DEPTH = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	input  wire logic         s_tready,
	input  wire logic [271:0] s_tdata,
	input  wire logic [2:0]   s_tuser,
	input  wire logic         m_tvalid,
	input  wire logic         m_tready,
	input  wire logic [7:0]   m_tdata,
	input  wire logic         cfg_we,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [4:0]   cfg_data,
	output int                errors,
	output int                pending,
	output int                checks_done,
	output int                loads_done
);

	typedef struct packed {
		logic [1:0]  pad;
		logic [63:0] peer_lo;
		logic [63:0] peer_hi;
		logic        peer_fam;
		logic [7:0]  pfx;
		logic [63:0] lo;
		logic [63:0] hi;
		logic        fam;
		logic [3:0]  idx;
	} subnet_beat_t;

	logic       virt_on, host_req, public_ok, private_on, all_ok;
	logic [4:0] n_allow, n_deny, n_conn;
	vspc_pkg::entry_t subnets [int'(vspc_pkg::NUM_TABLES) * LIST_DEPTH];
	logic [1:0] verdicts_due [$];

	function automatic logic [127:0] prefix_mask(logic fam, logic [7:0] pfx);
		if (fam)
			return (pfx >= vspc_pkg::HOST_PFX_V6) ? '1 : ~({128{1'b1}} >> pfx);
		return {96'd0, ~(32'hFFFF_FFFF >>
			((pfx > vspc_pkg::HOST_PFX_V4) ? vspc_pkg::HOST_PFX_V4 : pfx))};
	endfunction

	function automatic logic covers(int slot, logic fam, logic [127:0] addr, logic [7:0] pfx);
		vspc_pkg::entry_t e;
		e = subnets[slot];
		return e.fam == fam && pfx >= e.pfx &&
			((addr ^ {e.hi, e.lo}) & prefix_mask(e.fam, e.pfx)) == '0;
	endfunction

	function automatic logic listed(int tbl, logic [4:0] count, logic fam,
			logic [127:0] addr, logic [7:0] pfx);
		int n;
		logic hit;
		n = (count > LIST_DEPTH) ? LIST_DEPTH : int'(count);
		hit = 1'b0;
		for (int i = 0; i < n; i++)
			if (covers(tbl * LIST_DEPTH + i, fam, addr, pfx))
				hit = 1'b1;
		return hit;
	endfunction

	function automatic logic [1:0] policy_verdict(logic fam, logic [127:0] addr,
			logic [7:0] pfx, logic peer_fam, logic [127:0] peer);
		logic host;
		logic [1:0] why;
		host = pfx == (fam ? vspc_pkg::HOST_PFX_V6 : vspc_pkg::HOST_PFX_V4);
		why = vspc_pkg::VC_ACCEPT;
		if (!virt_on)
			return vspc_pkg::VC_ACCEPT;
		if (host_req && !host)
			return vspc_pkg::VC_HOST;
		if (public_ok && host && peer_fam == fam && peer == addr)
			return vspc_pkg::VC_ACCEPT;
		if (private_on) begin
			if (listed(vspc_pkg::TBL_ALLOW, n_allow, fam, addr, pfx) &&
					!listed(vspc_pkg::TBL_DENY, n_deny, fam, addr, pfx))
				return vspc_pkg::VC_ACCEPT;
			why = vspc_pkg::VC_PRIVATE;
		end
		if (n_conn != 0) begin
			if (listed(vspc_pkg::TBL_CONN, n_conn, fam, addr, pfx))
				return vspc_pkg::VC_ACCEPT;
			why = vspc_pkg::VC_SPECIFIC;
		end
		if (all_ok)
			return vspc_pkg::VC_ACCEPT;
		return why;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		subnet_beat_t b;
		logic [1:0] want;
		logic [127:0] addr, peer;
		if (!arst_n) begin
			virt_on = 1'b0;
			host_req = 1'b0;
			public_ok = 1'b0;
			private_on = 1'b0;
			all_ok = 1'b0;
			n_allow = '0;
			n_deny = '0;
			n_conn = '0;
			verdicts_due.delete();
			errors = 0;
			pending = 0;
			checks_done = 0;
			loads_done = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (verdicts_due.size() == 0) begin
					errors++;
					$display("%0t: verdict beat (allowed %0b code %0d) with no check outstanding",
						$time, m_tdata[0], m_tdata[2:1]);
				end else begin
					want = verdicts_due.pop_front();
					if (m_tdata[0] !== (want == vspc_pkg::VC_ACCEPT)) begin
						errors++;
						$display("%0t: allowed expected %0b actual %0b",
							$time, want == vspc_pkg::VC_ACCEPT, m_tdata[0]);
					end
					if (m_tdata[2:1] !== want) begin
						errors++;
						$display("%0t: verdict_code expected %0d actual %0d",
							$time, want, m_tdata[2:1]);
					end
				end
			end
			if (s_tvalid && s_tready) begin
				b = subnet_beat_t'(s_tdata);
				addr = b.fam ? {b.hi, b.lo} : {96'd0, b.lo[31:0]};
				if (s_tuser[0] == vspc_pkg::REQ_CHECK) begin
					peer = b.peer_fam ? {b.peer_hi, b.peer_lo}
						: {96'd0, b.peer_lo[31:0]};
					verdicts_due.push_back(policy_verdict(b.fam, addr, b.pfx,
						b.peer_fam, peer));
					checks_done++;
				end else begin
					if (s_tuser[2:1] < vspc_pkg::NUM_TABLES && int'(b.idx) < LIST_DEPTH)
						subnets[s_tuser[2:1] * LIST_DEPTH + b.idx] =
							'{fam: b.fam, pfx: b.pfx, hi: addr[127:64], lo: addr[63:0]};
					loads_done++;
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					vspc_pkg::REG_VIRT_ENABLED:  virt_on = cfg_data[0];
					vspc_pkg::REG_HOST_ONLY:     host_req = cfg_data[0];
					vspc_pkg::REG_ACCEPT_PUBLIC: public_ok = cfg_data[0];
					vspc_pkg::REG_USE_PRIVATE:   private_on = cfg_data[0];
					vspc_pkg::REG_ACCEPT_ALL:    all_ok = cfg_data[0];
					vspc_pkg::REG_CNT_ALLOW:     n_allow = cfg_data;
					vspc_pkg::REG_CNT_DENY:      n_deny = cfg_data;
					vspc_pkg::REG_CNT_CONN:      n_conn = cfg_data;
					default: ;
				endcase
			end
			pending = verdicts_due.size();
		end
	end

endmodule

// File: tb/sv/tb_virtual_subnet_policy_check_top.sv
`timescale 1ns / 1ps
// tb_virtual_subnet_policy_check_top: table loads, directed and random subnet checks
// under many policy settings; needs vspc_pkg, the block and subnet_policy_checker

module tb_virtual_subnet_policy_check_top;

	localparam int   DEPTH        = 16;
	localparam logic FAM_V4       = 1'b0;
	localparam logic FAM_V6       = 1'b1;
	localparam int   GAP_PCT      = 32;
	localparam int   DRAIN_CYCLES = 60;
	localparam int   NUM_PLANS    = 10;
	localparam int   PLAN_ITEMS   = 32;

	typedef struct {
		logic        req;
		logic [1:0]  tbl;
		logic [3:0]  idx;
		logic        fam;
		logic [63:0] hi;
		logic [63:0] lo;
		logic [7:0]  pfx;
		logic        pfam;
		logic [63:0] phi;
		logic [63:0] plo;
	} subnet_req_t;

	typedef struct packed {
		logic       virt;
		logic       host;
		logic       pub;
		logic       priv;
		logic       all;
		logic [4:0] n_allow;
		logic [4:0] n_deny;
		logic [4:0] n_conn;
	} policy_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [271:0] s_tdata;
	logic [2:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [7:0]   m_tdata;
	logic         cfg_we;
	logic [2:0]   cfg_index;
	logic [4:0]   cfg_data;
	logic         gaps_on = 1'b1;
	int           errors, pending, checks_done, loads_done;
	subnet_req_t  loaded [int'(vspc_pkg::NUM_TABLES) * DEPTH];

	virtual_subnet_policy_check_top #(.LIST_DEPTH(DEPTH)) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	subnet_policy_checker #(.LIST_DEPTH(DEPTH)) i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.errors      (errors),
		.pending     (pending),
		.checks_done (checks_done),
		.loads_done  (loads_done)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	initial begin
		#5_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	always @(negedge clk) begin
		m_tready <= !gaps_on || ($urandom_range(99) >= GAP_PCT);
	end

	task automatic offer(input subnet_req_t r);
		while (gaps_on && $urandom_range(99) < GAP_PCT) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser <= {r.tbl, r.req};
		s_tdata <= {2'b00, r.plo, r.phi, r.pfam, r.pfx, r.lo, r.hi, r.fam, r.idx};
		if (r.req == vspc_pkg::REQ_LOAD && r.tbl < vspc_pkg::NUM_TABLES)
			loaded[r.tbl * DEPTH + r.idx] = r;
		do @(posedge clk); while (!s_tready);
	endtask

	// sender holds off until every verdict is back and the block is quiet
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] index, input logic [4:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
	endtask

	task automatic apply_policy(input policy_t p);
		drain();
		write_reg(vspc_pkg::REG_VIRT_ENABLED, {4'($urandom), p.virt});
		write_reg(vspc_pkg::REG_HOST_ONLY, {4'($urandom), p.host});
		write_reg(vspc_pkg::REG_ACCEPT_PUBLIC, {4'($urandom), p.pub});
		write_reg(vspc_pkg::REG_USE_PRIVATE, {4'($urandom), p.priv});
		write_reg(vspc_pkg::REG_ACCEPT_ALL, {4'($urandom), p.all});
		write_reg(vspc_pkg::REG_CNT_ALLOW, p.n_allow);
		write_reg(vspc_pkg::REG_CNT_DENY, p.n_deny);
		write_reg(vspc_pkg::REG_CNT_CONN, p.n_conn);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic subnet_req_t random_entry();
		subnet_req_t r;
		int host, roll;
		r.req = vspc_pkg::REQ_LOAD;
		r.tbl = ($urandom_range(99) < 5) ? vspc_pkg::NUM_TABLES : 2'($urandom_range(2));
		r.idx = 4'($urandom);
		r.fam = 1'($urandom);
		r.hi = {$urandom, $urandom};
		r.lo = {$urandom, $urandom};
		r.pfam = 1'($urandom);
		r.phi = {$urandom, $urandom};
		r.plo = {$urandom, $urandom};
		host = r.fam ? int'(vspc_pkg::HOST_PFX_V6) : int'(vspc_pkg::HOST_PFX_V4);
		roll = $urandom_range(99);
		if (roll < 8)
			r.pfx = 8'd0;
		else if (roll < 18)
			r.pfx = 8'($urandom_range(255, host + 1));
		else
			r.pfx = 8'($urandom_range(host, host / 4));
		return r;
	endfunction

	// most checks are built from a loaded entry so that table hits are common
	function automatic subnet_req_t random_check();
		subnet_req_t r, e;
		logic [127:0] m;
		int host, l, roll;
		r = random_entry();
		r.req = vspc_pkg::REQ_CHECK;
		if ($urandom_range(99) < 60) begin
			e = loaded[$urandom_range(int'(vspc_pkg::NUM_TABLES) * DEPTH - 1)];
			r.fam = e.fam;
			host = e.fam ? int'(vspc_pkg::HOST_PFX_V6) : int'(vspc_pkg::HOST_PFX_V4);
			l = (int'(e.pfx) > host) ? host : int'(e.pfx);
			m = e.fam ? ~({128{1'b1}} >> l) : {96'd0, ~(32'hFFFF_FFFF >> l)};
			{r.hi, r.lo} = ({r.hi, r.lo} & ~m) | ({e.hi, e.lo} & m);
			roll = $urandom_range(99);
			if (roll < 70)
				r.pfx = (int'(e.pfx) > host) ? 8'(e.pfx + $urandom_range(255 - e.pfx))
					: 8'($urandom_range(host, e.pfx));
			else if (roll < 85)
				r.pfx = 8'(host);
			else
				r.pfx = 8'($urandom_range(255));
		end
		if ($urandom_range(99) < 20) begin
			r.pfx = r.fam ? vspc_pkg::HOST_PFX_V6 : vspc_pkg::HOST_PFX_V4;
			r.pfam = r.fam;
			r.phi = r.fam ? r.hi : {$urandom, $urandom};
			r.plo = r.fam ? r.lo : {32'($urandom), r.lo[31:0]};
		end
		return r;
	endfunction

	function automatic subnet_req_t entry(logic [1:0] tbl, logic [3:0] idx, logic fam,
			logic [63:0] hi, logic [63:0] lo, logic [7:0] pfx);
		subnet_req_t r;
		r = random_entry();
		r.tbl = tbl;
		r.idx = idx;
		r.fam = fam;
		r.hi = hi;
		r.lo = lo;
		r.pfx = pfx;
		return r;
	endfunction

	function automatic subnet_req_t probe(logic fam, logic [63:0] hi, logic [63:0] lo,
			logic [7:0] pfx, logic pfam, logic [63:0] phi, logic [63:0] plo);
		subnet_req_t r;
		r = random_entry();
		r.req = vspc_pkg::REQ_CHECK;
		r.fam = fam;
		r.hi = hi;
		r.lo = lo;
		r.pfx = pfx;
		r.pfam = pfam;
		r.phi = phi;
		r.plo = plo;
		return r;
	endfunction

	function automatic logic [4:0] random_count();
		case ($urandom_range(3))
			0: return 5'd0;
			1: return 5'(DEPTH);
			2: return 5'd31;
			default: return 5'($urandom_range(DEPTH, 1));
		endcase
	endfunction

	initial begin
		subnet_req_t r;
		policy_t plans [NUM_PLANS];
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// fill every entry of every table before any count is raised
		for (int slot = 0; slot < int'(vspc_pkg::NUM_TABLES) * DEPTH; slot++) begin
			r = random_entry();
			r.tbl = 2'(slot / DEPTH);
			r.idx = 4'(slot % DEPTH);
			offer(r);
		end
		offer(entry(vspc_pkg::TBL_ALLOW, 4'd0, FAM_V4, 64'hDEAD_BEEF_0123_4567,
			64'hFFFF_FFFF_0A00_0000, 8'd8));
		offer(entry(vspc_pkg::TBL_ALLOW, 4'd1, FAM_V6, 64'hFD00_0000_0000_0000, 64'd0, 8'd8));
		offer(entry(vspc_pkg::TBL_ALLOW, 4'd2, FAM_V4, 64'd0, 64'h0000_0000_C0A8_0101, 8'd40));
		offer(entry(vspc_pkg::TBL_ALLOW, 4'd3, FAM_V6, '1, '1, vspc_pkg::HOST_PFX_V6));
		offer(entry(vspc_pkg::TBL_DENY, 4'd0, FAM_V4, 64'd0, 64'h0000_0000_0A01_0000, 8'd16));
		offer(entry(vspc_pkg::TBL_DENY, 4'd1, FAM_V6, 64'hFD00_0001_0000_0000, 64'd0, 8'd200));
		offer(entry(vspc_pkg::TBL_CONN, 4'd0, FAM_V4, 64'd0, 64'h0000_0000_AC10_0000, 8'd12));
		offer(entry(vspc_pkg::TBL_CONN, 4'd1, FAM_V6, 64'h2001_0DB8_0000_0000, 64'd0, 8'd32));
		offer(entry(vspc_pkg::NUM_TABLES, 4'd0, FAM_V4, 64'd0, 64'd0, 8'd0));

		// virtual description off: anything goes
		offer(probe(FAM_V4, '1, '1, 8'd255, FAM_V6, '1, '1));
		offer(probe(FAM_V6, 64'd0, 64'd0, 8'd0, FAM_V4, 64'd0, 64'd0));

		apply_policy('{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 5'd4, 5'd2, 5'd2});
		offer(probe(FAM_V4, 64'd0, 64'h0A02_0300, 8'd24, FAM_V4, 64'd0, 64'd0));
		offer(probe(FAM_V4, 64'd0, 64'h0A01_0500, 8'd24, FAM_V4, 64'd0, 64'd0));
		offer(probe(FAM_V4, 64'd0, 64'hAC10_0500, 8'd24, FAM_V4, 64'd0, 64'd0));
		offer(probe(FAM_V4, 64'd0, 64'h0A00_0000, 8'd4, FAM_V4, 64'd0, 64'd0));
		offer(probe(FAM_V6, 64'hFD12_0000_0000_0000, 64'd0, 8'd64, FAM_V6, 64'd0, 64'd0));
		offer(probe(FAM_V4, '1, 64'hFFFF_FFFF_0A0B_0C0D, 8'd32, FAM_V4, 64'd0, 64'd0));
		offer(probe(FAM_V4, 64'd0, 64'h0808_0808, 8'd32, FAM_V4, '1,
			64'h1234_5678_0808_0808));
		offer(probe(FAM_V4, 64'd0, 64'h0808_0808, 8'd32, FAM_V6, 64'd0, 64'h0808_0808));
		offer(probe(FAM_V4, 64'd0, 64'hC0A8_0101, 8'd40, FAM_V4, 64'd0, 64'd0));
		offer(probe(FAM_V6, '1, '1, vspc_pkg::HOST_PFX_V6, FAM_V6, '1, '1));
		offer(probe(FAM_V6, 64'hFD00_0001_0000_0000, 64'd0, 8'd255, FAM_V6, 64'd0, 64'd0));
		offer(probe(FAM_V6, 64'h2001_0DB8_0001_0000, 64'd0, 8'd48, FAM_V6, 64'd0, 64'd0));

		apply_policy('{1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 5'd0, 5'd0, 5'd0});
		offer(probe(FAM_V4, 64'd0, 64'h0A00_0000, 8'd24, FAM_V4, 64'd0, 64'd0));
		offer(probe(FAM_V4, 64'd0, 64'h0102_0304, vspc_pkg::HOST_PFX_V4, FAM_V4,
			64'd0, 64'd0));
		offer(probe(FAM_V6, 64'h2001_0DB8_0000_0000, 64'd1, vspc_pkg::HOST_PFX_V6, FAM_V4,
			64'd0, 64'd0));
		offer(probe(FAM_V6, 64'h2001_0DB8_0000_0000, 64'd1, 8'd127, FAM_V6, 64'd0, 64'd0));
		offer(probe(FAM_V4, 64'd0, 64'd0, 8'd0, FAM_V4, 64'd0, 64'd0));

		plans[0] = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 5'd0, 5'd0, 5'd0};
		plans[1] = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 5'(DEPTH), 5'(DEPTH), 5'(DEPTH)};
		plans[2] = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 5'd31, 5'd31, 5'd31};
		plans[3] = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 5'(DEPTH), 5'(DEPTH), 5'(DEPTH)};
		plans[4] = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 5'd31, 5'd31, 5'd31};
		for (int p = 0; p < NUM_PLANS; p++) begin
			if (p >= 5)
				plans[p] = '{$urandom_range(99) < 85, 1'($urandom), 1'($urandom),
					1'($urandom), 1'($urandom), random_count(), random_count(),
					random_count()};
			apply_policy(plans[p]);
			gaps_on = !(p == 2 || p == 3);
			for (int k = 0; k < PLAN_ITEMS; k++)
				offer(($urandom_range(99) < 20) ? random_entry() : random_check());
		end
		gaps_on = 1'b1;
		drain();

		$display("sent %0d check beats and %0d load beats over %0d policy settings,",
			checks_done, loads_done, NUM_PLANS + 3);
		$display("every verdict compared field by field against the predicted one");
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
